@@ hdl/mres_pkg.sv @@
// package for the multiplexed rotary encoder scanner
// types, codes and the slot order table shared by the scanner modules
// no dependencies
`default_nettype none

package mres_pkg;

  // number of physical channels that the order table reaches
  localparam int unsigned CH_DEPTH = 8;
  localparam int unsigned CH_W     = 3;
  localparam int unsigned POS_W    = 15;
  localparam int unsigned STROBE_W = 8;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned MAXR_W   = 63;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STROBE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SW_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOW      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HIGH     = 2'd3;

  // reset values
  localparam logic [STROBE_W-1:0] STROBE_COUNT_RST  = 8'd3;
  localparam logic [WIN_W-1:0]    SW_WINDOW_RST     = 16'd50;
  localparam logic [MAXR_W-1:0]   MAX_RST = 63'h7FFF_7FFF_7FFF_7FFF;
  localparam logic [POS_W-1:0]    POS_CLIP = 15'h7FFF;

  // moved codes
  localparam logic [1:0] MOVED_NONE = 2'd0;
  localparam logic [1:0] MOVED_UP   = 2'd1;
  localparam logic [1:0] MOVED_DOWN = 2'd2;

  typedef struct packed {
    logic                prev_clock;
    logic [STROBE_W-1:0] strobe;
    logic                sw_deb;
    logic [STAMP_W-1:0]  sw_stamp;
    logic [POS_W-1:0]    pos;
  } chan_state_t;

  typedef struct packed {
    logic [STROBE_W-1:0] strobe_count;
    logic [WIN_W-1:0]    sw_window;
    logic [POS_W-1:0]    lane_max;
  } chan_cfg_t;

  // mux slot to physical channel
  function automatic logic [CH_W-1:0] order_map(input logic [CH_W-1:0] slot);
    logic [CH_W-1:0] ch;
    unique case (slot)
      3'd0:    ch = 3'd6;
      3'd1:    ch = 3'd7;
      3'd2:    ch = 3'd0;
      3'd3:    ch = 3'd1;
      3'd4:    ch = 3'd2;
      3'd5:    ch = 3'd5;
      3'd6:    ch = 3'd4;
      default: ch = 3'd3;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ hdl/mres_chan_update.sv @@
// next-state logic for one encoder channel: switch debounce, clock edge qualification and position count
// depends on mres_pkg
`default_nettype none

module mres_chan_update
  import mres_pkg::*;
(
  input  chan_state_t        cur,
  input  chan_cfg_t          cfg,
  input  logic               clk_level,
  input  logic               data_level,
  input  logic               switch_level,
  input  logic [STAMP_W-1:0] now_ms,
  output chan_state_t        nxt,
  output logic [1:0]         moved,
  output logic               toggled
);

  logic [STAMP_W-1:0]  elapsed;
  logic [POS_W:0]      pos_inc;
  logic [STROBE_W-1:0] strobe_inc;

  assign elapsed    = now_ms - cur.sw_stamp;
  assign pos_inc    = {1'b0, cur.pos} + {{POS_W{1'b0}}, 1'b1};
  assign strobe_inc = cur.strobe + {{(STROBE_W-1){1'b0}}, 1'b1};

  always_comb begin
    nxt     = cur;
    moved   = MOVED_NONE;
    toggled = 1'b0;

    // switch accepted only once the window since the last change has passed
    if (cur.sw_deb != switch_level &&
        elapsed > {{(STAMP_W-WIN_W){1'b0}}, cfg.sw_window}) begin
      nxt.sw_deb   = ~cur.sw_deb;
      nxt.sw_stamp = now_ms;
      toggled      = 1'b1;
    end

    if (clk_level == cur.prev_clock) begin
      if (cur.strobe < cfg.strobe_count) nxt.strobe = strobe_inc;
    end else if (cur.strobe < cfg.strobe_count) begin
      nxt.strobe = '0;
    end else if (cur.strobe == cfg.strobe_count) begin
      // first strobe at the top of the count, steps one past it
      nxt.strobe = strobe_inc;
    end else begin
      // confirmed edge
      nxt.prev_clock = clk_level;
      nxt.strobe     = '0;
      if (~clk_level ^ data_level) begin
        if (cur.pos != '0) nxt.pos = cur.pos - {{(POS_W-1){1'b0}}, 1'b1};
        moved = MOVED_DOWN;
      end else begin
        if (pos_inc <= {1'b0, cfg.lane_max}) nxt.pos = pos_inc[POS_W-1:0];
        moved = MOVED_UP;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/muxed_rotary_encoder_scanner.sv @@
// top level of the multiplexed rotary encoder scanner
// depends on mres_pkg and mres_chan_update
//
// Takes one scan sample word per cycle on the in_ stream, unless the output stalls, and
// returns one result word per sample on the out_ stream, in order. A sample is held in an
// input register; from there the channel state is read, updated by mres_chan_update and
// written back while the result is captured in the output register, so throughput is one
// word per cycle unless stalled, limited only by the single read-modify-write of the
// per-channel state. Back-to-back samples on the same channel see the updated state with
// no hazard. While a result waits, input is taken only into an empty input register.
// Slots at or above CHANNELS are reported with the channel's stored state and no movement.
// Configuration writes through cfg_ take effect at once and belong to idle periods.
`default_nettype none

module muxed_rotary_encoder_scanner
  import mres_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input words
  input  wire logic                 in_tvalid,
  output      logic                 in_tready,
  // mux_slot[2:0], clk_level[3], data_level[4], switch_level[5], now_ms[37:6], zero fill
  input  wire logic [39:0]          in_tdata,
  // result words
  output      logic                 out_tvalid,
  input  wire logic                 out_tready,
  // channel[2:0], position[17:3], moved[19:18], switch_state[20], switch_toggled[21], fill
  output      logic [23:0]          out_tdata,
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAXR_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [STROBE_W-1:0] strobe_count_r;
  logic [WIN_W-1:0]    sw_window_r;
  logic [MAXR_W-1:0]   max_low_r;
  logic [MAXR_W-1:0]   max_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_count_r <= STROBE_COUNT_RST;
      sw_window_r    <= SW_WINDOW_RST;
      max_low_r      <= MAX_RST;
      max_high_r     <= MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STROBE_COUNT: strobe_count_r <= cfg_wdata[STROBE_W-1:0];
        CFG_SW_WINDOW:    sw_window_r    <= cfg_wdata[WIN_W-1:0];
        CFG_MAX_LOW:      max_low_r      <= cfg_wdata;
        CFG_MAX_HIGH:     max_high_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic               in_valid_r;
  logic [CH_W-1:0]    slot_r;
  logic               clk_lvl_r;
  logic               data_lvl_r;
  logic               sw_lvl_r;
  logic [STAMP_W-1:0] now_r;
  logic               out_valid_r;
  logic               advance;

  // the input register moves on whenever the output register is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      slot_r     <= in_tdata[2:0];
      clk_lvl_r  <= in_tdata[3];
      data_lvl_r <= in_tdata[4];
      sw_lvl_r   <= in_tdata[5];
      now_r      <= in_tdata[37:6];
    end
  end

  // per-channel state, indexed by physical channel
  chan_state_t st_r [CH_DEPTH];

  logic [CH_W-1:0] ch;
  logic            slot_ok;
  logic            fire;
  logic [63:0]     max_word;
  logic [15:0]     lane_raw;
  chan_cfg_t       ccfg;
  chan_state_t     cur;
  chan_state_t     nxt;
  logic [1:0]      moved;
  logic            toggled;

  assign ch      = order_map(slot_r);
  assign slot_ok = 32'(slot_r) < CHANNELS;
  assign fire    = in_valid_r && advance;
  assign cur     = st_r[ch];

  // lane maximum of the channel, clipped to the position range
  assign max_word = {1'b0, (ch[2] ? max_high_r : max_low_r)};
  assign lane_raw = max_word[{ch[1:0], 4'b0000} +: 16];

  assign ccfg.strobe_count = strobe_count_r;
  assign ccfg.sw_window    = sw_window_r;
  assign ccfg.lane_max     = lane_raw[15] ? POS_CLIP : lane_raw[POS_W-1:0];

  mres_chan_update u_update (
    .cur          (cur),
    .cfg          (ccfg),
    .clk_level    (clk_lvl_r),
    .data_level   (data_lvl_r),
    .switch_level (sw_lvl_r),
    .now_ms       (now_r),
    .nxt          (nxt),
    .moved        (moved),
    .toggled      (toggled)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CH_DEPTH; i++) begin
        st_r[i].prev_clock <= 1'b1;
        st_r[i].strobe     <= '0;
        st_r[i].sw_deb     <= 1'b0;
        st_r[i].sw_stamp   <= '0;
        st_r[i].pos        <= '0;
      end
    end else if (fire && slot_ok) begin
      st_r[ch] <= nxt;
    end
  end

  // output register
  logic [CH_W-1:0]  out_ch_r;
  logic [POS_W-1:0] out_pos_r;
  logic [1:0]       out_moved_r;
  logic             out_sw_r;
  logic             out_tog_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch_r    <= ch;
      out_pos_r   <= slot_ok ? nxt.pos : cur.pos;
      out_moved_r <= slot_ok ? moved : MOVED_NONE;
      out_sw_r    <= slot_ok ? nxt.sw_deb : cur.sw_deb;
      out_tog_r   <= slot_ok && toggled;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_tog_r, out_sw_r, out_moved_r, out_pos_r, out_ch_r};

  // a sample taken into the update stage always yields a result next cycle
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed sample produced no result");

  // an ignored slot never reports movement or a switch change
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !slot_ok) |=> (out_moved_r == MOVED_NONE && !out_tog_r))
    else $error("ignored slot reported activity");

  // with the output register empty the input side must be open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  // a toggle in the result means the stored switch state flipped
  a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && slot_ok && toggled) |=> (st_r[$past(ch)].sw_deb != $past(cur.sw_deb)))
    else $error("switch toggle without state change");

endmodule

`default_nettype wire
